// File: rtl/sdt_pkg.sv
// shared types and constants for the seen-device table
// no dependencies
package sdt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = 48;
    localparam int STRENGTH_W  = 8;
    localparam int TIME_W      = 32;
    localparam int OUTCOME_W   = 2;
    localparam int COUNT_W     = 8;

    localparam logic [OUTCOME_W-1:0] OUTCOME_UPDATE = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_INSERT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT  = 2'd2;

    typedef struct packed {
        logic                         valid;
        logic [ADDR_W-1:0]            address;
        logic signed [STRENGTH_W-1:0] strength;
        logic [TIME_W-1:0]            last_seen;
    } entry_t;

endpackage

// File: rtl/sdt_cell.sv
// one table entry of the ring: holds an entry, passes it to its neighbor on shift
// depends on sdt_pkg
module sdt_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  sdt_pkg::entry_t from_next,
    input  logic           wr_en,
    input  sdt_pkg::entry_t wr_data,
    output sdt_pkg::entry_t entry
);

    logic            valid_reg;
    sdt_pkg::entry_t data_reg;
    sdt_pkg::entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        data_next.valid = valid_reg;
        if (wr_en)
        begin
            data_next = wr_data;
        end
        else if (shift)
        begin
            data_next = from_next;
        end
    end

    // valid is control state, the rest is payload without reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= data_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        entry = data_reg;
        entry.valid = valid_reg;
    end

endmodule

// File: rtl/sdt_chain.sv
// ring of table cells; the head (cell 0) presents one entry per shift
// depends on sdt_pkg, sdt_cell
module sdt_chain
#(
    parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_slot,
    input  sdt_pkg::entry_t  wr_data,
    output sdt_pkg::entry_t  head
);

    sdt_pkg::entry_t cells [TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic cell_wr;
            assign cell_wr = wr_en && (wr_slot == IDX_W'(g));

            sdt_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .from_next (cells[(g + 1) % TABLE_DEPTH]),
                .wr_en     (cell_wr),
                .wr_data   (wr_data),
                .entry     (cells[g])
            );
        end
    endgenerate

    assign head = cells[0];

endmodule

// File: rtl/seen_device_table_oldest_evict.sv
// seen-device table with oldest-first eviction, top level and scan control
// depends on sdt_pkg, sdt_chain
//
// usage: raise start with an observation (device_address, signal_strength,
// time_ms); it is taken at a clock edge where start is high and busy is low.
// the table is a ring of TABLE_DEPTH cells that rotates one place per cycle
// while scanning, so the head cell sees every entry once per turn; the lookup,
// the lowest free slot and the oldest entry are tracked there. after a full
// turn the ring is back home and the chosen slot is written in the write state.
// the result is registered at the end of the write state and shows for
// one cycle with done high (outcome, evicted_address, device_count).
// a new observation is not taken until the last one is through: busy is high
// through the scan and the write state; busy is low during the
// done cycle, so the next start may be taken there.
// reset clears all valid bits and the count at once; no sweep is needed.
// the receiver cannot stall: each result is there for exactly one cycle.
module seen_device_table_oldest_evict
#(
    parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [sdt_pkg::ADDR_W-1:0]           device_address,
    input  logic signed [sdt_pkg::STRENGTH_W-1:0] signal_strength,
    input  logic [sdt_pkg::TIME_W-1:0]           time_ms,
    output logic                                 done,
    output logic [sdt_pkg::OUTCOME_W-1:0]        outcome,
    output logic [sdt_pkg::ADDR_W-1:0]           evicted_address,
    output logic [sdt_pkg::COUNT_W-1:0]          device_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > sdt_pkg::COUNT_W) ? CNT_W : sdt_pkg::COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic done_reg, done_next;

    logic [sdt_pkg::ADDR_W-1:0]            key_reg;
    logic signed [sdt_pkg::STRENGTH_W-1:0] strength_reg;
    logic [sdt_pkg::TIME_W-1:0]            now_reg;

    logic found_reg, found_next;
    logic have_free_reg, have_free_next;
    logic have_old_reg, have_old_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] old_reg, old_next;
    logic [sdt_pkg::TIME_W-1:0] old_seen_reg, old_seen_next;
    logic [sdt_pkg::ADDR_W-1:0] old_addr_reg, old_addr_next;

    logic [sdt_pkg::OUTCOME_W-1:0] outcome_reg, outcome_next;
    logic [sdt_pkg::ADDR_W-1:0]    evicted_reg, evicted_next;

    logic            shift;
    logic            wr_en;
    logic [IDX_W-1:0] wr_slot;
    sdt_pkg::entry_t wr_data;
    sdt_pkg::entry_t head;
    logic            accept;
    logic [EXT_W-1:0] count_wide;

    sdt_chain
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    )
    u_chain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_data (wr_data),
        .head    (head)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign shift  = (state_reg == ST_SCAN);

    always_comb
    begin
        wr_data.valid     = 1'b1;
        wr_data.address   = key_reg;
        wr_data.strength  = strength_reg;
        wr_data.last_seen = now_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        have_free_next = have_free_reg;
        have_old_next  = have_old_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        old_next       = old_reg;
        old_seen_next  = old_seen_reg;
        old_addr_next  = old_addr_reg;
        outcome_next   = outcome_reg;
        evicted_next   = evicted_reg;
        wr_en          = 1'b0;
        wr_slot        = hit_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_SCAN;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    have_free_next = 1'b0;
                    have_old_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (head.valid)
                begin
                    if (!found_reg && head.address == key_reg)
                    begin
                        found_next = 1'b1;
                        hit_next   = idx_reg;
                    end
                    // oldest time wins, equal times go to the lower address
                    if (!have_old_reg || head.last_seen < old_seen_reg ||
                        (head.last_seen == old_seen_reg && head.address < old_addr_reg))
                    begin
                        have_old_next = 1'b1;
                        old_next      = idx_reg;
                        old_seen_next = head.last_seen;
                        old_addr_next = head.address;
                    end
                end
                else if (!have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_next      = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                wr_en        = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
                evicted_next = '0;
                if (found_reg)
                begin
                    wr_slot      = hit_reg;
                    outcome_next = sdt_pkg::OUTCOME_UPDATE;
                end
                else if (have_free_reg)
                begin
                    wr_slot      = free_reg;
                    count_next   = count_reg + 1'b1;
                    outcome_next = sdt_pkg::OUTCOME_INSERT;
                end
                else
                begin
                    wr_slot      = old_reg;
                    evicted_next = old_addr_reg;
                    outcome_next = sdt_pkg::OUTCOME_EVICT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg      <= device_address;
            strength_reg <= signal_strength;
            now_reg      <= time_ms;
        end
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        have_free_reg <= have_free_next;
        have_old_reg  <= have_old_next;
        hit_reg       <= hit_next;
        free_reg      <= free_next;
        old_reg       <= old_next;
        old_seen_reg  <= old_seen_next;
        old_addr_reg  <= old_addr_next;
        outcome_reg   <= outcome_next;
        evicted_reg   <= evicted_next;
    end

    assign count_wide      = EXT_W'(count_reg);
    assign done            = done_reg;
    assign outcome         = outcome_reg;
    assign evicted_address = evicted_reg;
    assign device_count    = count_wide[sdt_pkg::COUNT_W-1:0];

endmodule

// File: sim/tb_top.sv
// testbench for seen_device_table_oldest_evict: drives observations, tracks the device table
// in a scoreboard class and checks every result strobe against the oldest expected report
// depends on rtl/sdt_pkg.sv and rtl/seen_device_table_oldest_evict.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESULT_LATENCY = sdt_pkg::TABLE_DEPTH + 1;
    localparam int          RANDOM_ITEMS   = 750;
    localparam int          QUIET_TAIL     = 100;
    localparam int          POOL_SIZE      = 200;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;

    typedef struct packed {
        logic [sdt_pkg::OUTCOME_W-1:0] outcome;
        logic [sdt_pkg::ADDR_W-1:0]    evicted;
        logic [sdt_pkg::COUNT_W-1:0]   count;
    } report_t;

    class seen_table_tracker;
        bit                             slot_valid[sdt_pkg::TABLE_DEPTH];
        logic [sdt_pkg::ADDR_W-1:0]     slot_addr[sdt_pkg::TABLE_DEPTH];
        logic [sdt_pkg::STRENGTH_W-1:0] slot_strength[sdt_pkg::TABLE_DEPTH];
        logic [sdt_pkg::TIME_W-1:0]     slot_seen[sdt_pkg::TABLE_DEPTH];
        int unsigned                    live;
        report_t                        pending[$];
        int unsigned                    errors;

        function new();
            foreach (slot_valid[i])
            begin
                slot_valid[i] = 1'b0;
            end
            live   = 0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch %0d: %s", errors, msg);
        endfunction

        // one lookup pass: first hit, lowest free slot, oldest entry (ties to lowest address)
        function void note_observation(logic [sdt_pkg::ADDR_W-1:0] addr,
                                       logic [sdt_pkg::STRENGTH_W-1:0] strength,
                                       logic [sdt_pkg::TIME_W-1:0] now);
            int      hit;
            int      free_slot;
            int      oldest;
            int      slot;
            report_t rep;
            hit       = -1;
            free_slot = -1;
            oldest    = -1;
            rep       = '0;
            for (int i = 0; i < sdt_pkg::TABLE_DEPTH; i++)
            begin
                if (slot_valid[i])
                begin
                    if (hit < 0 && slot_addr[i] == addr)
                        hit = i;
                    if (oldest < 0 || slot_seen[i] < slot_seen[oldest] ||
                        (slot_seen[i] == slot_seen[oldest] &&
                         slot_addr[i] < slot_addr[oldest]))
                        oldest = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (hit >= 0)
            begin
                slot_strength[hit] = strength;
                slot_seen[hit]     = now;
                rep.outcome        = sdt_pkg::OUTCOME_UPDATE;
            end
            else
            begin
                if (free_slot >= 0)
                begin
                    slot        = free_slot;
                    live++;
                    rep.outcome = sdt_pkg::OUTCOME_INSERT;
                end
                else
                begin
                    slot        = oldest;
                    rep.evicted = slot_addr[oldest];
                    rep.outcome = sdt_pkg::OUTCOME_EVICT;
                end
                slot_valid[slot]    = 1'b1;
                slot_addr[slot]     = addr;
                slot_strength[slot] = strength;
                slot_seen[slot]     = now;
            end
            rep.count = live[sdt_pkg::COUNT_W-1:0];
            pending.push_back(rep);
        endfunction

        function void check_report(logic [sdt_pkg::OUTCOME_W-1:0] outcome,
                                   logic [sdt_pkg::ADDR_W-1:0] evicted,
                                   logic [sdt_pkg::COUNT_W-1:0] count);
            report_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("result with nothing expected: outcome %0d evicted %h count %0d",
                               outcome, evicted, count));
                return;
            end
            want = pending.pop_front();
            if (outcome !== want.outcome)
                flag($sformatf("outcome expected %0d got %0d", want.outcome, outcome));
            if (evicted !== want.evicted)
                flag($sformatf("evicted_address expected %h got %h", want.evicted, evicted));
            if (count !== want.count)
                flag($sformatf("device_count expected %0d got %0d", want.count, count));
        endfunction

        function void check_drained();
            if (pending.size() != 0)
                flag($sformatf("%0d expected results never arrived", pending.size()));
        endfunction
    endclass

    logic                                  clk;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    logic [sdt_pkg::ADDR_W-1:0]            device_address;
    logic signed [sdt_pkg::STRENGTH_W-1:0] signal_strength;
    logic [sdt_pkg::TIME_W-1:0]            time_ms;
    logic                                  done;
    logic [sdt_pkg::OUTCOME_W-1:0]         outcome;
    logic [sdt_pkg::ADDR_W-1:0]            evicted_address;
    logic [sdt_pkg::COUNT_W-1:0]           device_count;

    seen_table_tracker          table_book;
    logic [sdt_pkg::ADDR_W-1:0] addr_pool[POOL_SIZE];
    logic [sdt_pkg::TIME_W-1:0] clock_ms;

    seen_device_table_oldest_evict u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .device_address  (device_address),
        .signal_strength (signal_strength),
        .time_ms         (time_ms),
        .done            (done),
        .outcome         (outcome),
        .evicted_address (evicted_address),
        .device_count    (device_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            table_book.check_report(outcome, evicted_address, device_count);
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[seen_device_table_oldest_evict] ERROR");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_observation(input logic [sdt_pkg::ADDR_W-1:0] addr,
                                    input logic [sdt_pkg::STRENGTH_W-1:0] strength,
                                    input logic [sdt_pkg::TIME_W-1:0] now,
                                    input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            // sometimes hold the idle until the block is free, so it lands after done
            if ($urandom_range(0, 1) == 1)
            begin
                while (busy)
                    @(negedge clk);
            end
            repeat (gap) @(negedge clk);
        end
        start           <= 1'b1;
        device_address  <= addr;
        signal_strength <= strength;
        time_ms         <= now;
        do
            @(posedge clk);
        while (busy);
        table_book.note_observation(addr, strength, now);
        @(negedge clk);
    endtask

    function automatic logic [sdt_pkg::TIME_W-1:0] next_time();
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return '0;
            2: return '1;
            default:
            begin
                // small steps so equal last-seen times are common
                clock_ms = clock_ms + $urandom_range(0, 2);
                return clock_ms;
            end
        endcase
    endfunction

    initial
    begin : stimulus
        logic [sdt_pkg::ADDR_W-1:0]     addr;
        logic [sdt_pkg::STRENGTH_W-1:0] strength;
        int                             gap;
        rst_n           = 1'b0;
        start           = 1'b0;
        device_address  = '0;
        signal_strength = '0;
        time_ms         = '0;
        table_book      = new();
        clock_ms        = $urandom_range(0, 1000);
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = sdt_pkg::ADDR_W'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 48'h0000_0000_0001;
        addr_pool[3] = 48'h8000_0000_0000;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, updates, inserts, alternating bit patterns
        send_observation(48'h0, 8'h80, 32'h0, 0);
        send_observation('1, 8'h7F, '1, 0);
        send_observation(48'h0, 8'h00, 32'h1, 2);
        send_observation('1, 8'hFF, 32'h0, 0);
        send_observation(48'h8000_0000_0000, 8'h01, 32'h8000_0000, 0);
        send_observation(48'h5555_5555_5555, 8'h55, 32'h5555_5555, 3);
        send_observation(48'hAAAA_AAAA_AAAA, 8'hAA, 32'hAAAA_AAAA, 0);
        send_observation(48'h0000_0000_0001, 8'h80, 32'h0, 0);
        send_observation(48'h5555_5555_5555, 8'h7F, 32'h0, 1);
        send_observation(48'h0, 8'h80, 32'h0, 0);
        send_observation(48'hAAAA_AAAA_AAAA, 8'h00, '1, 0);

        // random: mostly a bounded address pool so the table fills, updates and evicts
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                addr = sdt_pkg::ADDR_W'({$urandom, $urandom});
            else
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            strength = sdt_pkg::STRENGTH_W'($urandom);
            if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 15);
            else
                gap = 0;
            send_observation(addr, strength, next_time(), gap);
        end
        start <= 1'b0;

        while (table_book.pending.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 8) @(posedge clk);
        table_book.check_drained();
        if (table_book.errors == 0)
            $display("[seen_device_table_oldest_evict] OK");
        else
            $display("[seen_device_table_oldest_evict] ERROR");
        $finish;
    end

endmodule
